[rtl/rss_pkg.sv]
// Shared types and constants for the ring sequence store.
// Used by rss_rem, rss_engine and ring_sequence_store; no dependencies.
package rss_pkg;

    // Capacity of the entry store and derived widths
    localparam int DEPTH     = 64;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);

    // Field widths fixed by the command format
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int SHIFT_W   = 32;
    localparam int XW        = COUNT_W + 1;
    localparam int IN_DATA_W = ((VALUE_W + COUNT_W + SHIFT_W + 7) / 8) * 8;

    // Remainder unit: one quotient bit per cycle
    localparam int REM_STEPS = SHIFT_W;
    localparam int STEP_W    = $clog2(REM_STEPS);

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_MOVE   = 2'd2,
        KIND_SHOW   = 2'd3
    } rss_kind_t;

    typedef struct packed {
        rss_kind_t                  kind;
        logic signed [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]         count;
        logic signed [SHIFT_W-1:0]  shift;
    } rss_cmd_t;

    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
        logic                       status;
    } rss_emit_t;

    typedef struct packed {
        logic                       start;
        logic [SHIFT_W-1:0]         dividend;
        logic [CW-1:0]              divisor;
    } rss_div_req_t;

    typedef struct packed {
        logic                       done;
        logic [CW-1:0]              rem;
    } rss_div_rsp_t;

    typedef struct packed {
        logic                       idle;
        logic [CW-1:0]              count;
    } rss_stat_t;

endpackage

[rtl/rss_rem.sv]
// Iterative remainder unit: 32-bit dividend modulo the entry count.
// Restoring scheme, one bit per cycle. Depends on rss_pkg.
module rss_rem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rss_pkg::rss_div_req_t req,
    output rss_pkg::rss_div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rss_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [rss_pkg::SHIFT_W-1:0]       quo_reg, quo_next;
    logic [rss_pkg::CW-1:0]            rem_reg, rem_next;
    logic [rss_pkg::CW-1:0]            div_reg, div_next;
    logic [rss_pkg::CW:0]              trial;

    // On start load the operands, else shift in the next dividend bit and subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[rss_pkg::SHIFT_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            step_next = rss_pkg::STEP_W'(rss_pkg::REM_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = rss_pkg::CW'(trial - {1'b0, div_reg});
            else
                rem_next = rss_pkg::CW'(trial);
            quo_next = quo_reg << 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/rss_engine.sv]
// Command sequencer around the entry memory: shifts entries for insert and
// erase, moves the head for move, walks the ring for show. Depends on rss_pkg and rss_rem.
module rss_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rss_pkg::rss_cmd_t             cmd,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rss_pkg::VALUE_W-1:0]   cfg_data,
    input  logic                          out_free,
    output rss_pkg::rss_emit_t            emit,
    output rss_pkg::rss_stat_t            stat
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_COPY      = 8'b0000_0010,
        ST_DRAIN     = 8'b0000_0100,
        ST_FILL      = 8'b0000_1000,
        ST_DIV       = 8'b0001_0000,
        ST_SHOW_RD   = 8'b0010_0000,
        ST_SHOW_WAIT = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } rss_state_t;

    localparam int AW = rss_pkg::AW;
    localparam int CW = rss_pkg::CW;
    localparam int XW = rss_pkg::XW;
    localparam int VW = rss_pkg::VALUE_W;

    rss_state_t           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        end_reg, end_next;
    logic [AW-1:0]        dist_reg, dist_next;
    logic [CW-1:0]        left_reg, left_next;
    logic                 up_reg, up_next;
    logic                 ins_reg, ins_next;
    logic                 st_reg, st_next;
    logic                 neg_reg, neg_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [VW-1:0]        value_reg, value_next;
    logic                 zero_valid_reg;
    logic                 rd_zero_reg;

    // Entry memory, one write and one registered read port
    logic [VW-1:0]        mem [rss_pkg::DEPTH];
    logic [VW-1:0]        rd_q_reg;
    logic                 rd_en;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [VW-1:0]        wdata;
    logic [VW-1:0]        rd_data;

    // Command decode arithmetic
    logic [XW-1:0]        n_x, h_x, cnt_x, room_x, most_x;
    logic                 ins_clip, era_clip, era_wrap;
    logic [XW-1:0]        ins_c, era_c, era_w, era_lo;
    logic [XW-1:0]        mv_raw, mv_r, mv_sum, mv_head;

    rss_pkg::rss_div_req_t div_req;
    rss_pkg::rss_div_rsp_t div_rsp;

    rss_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clip / clamp of the requested count
    assign n_x      = XW'(count_reg);
    assign h_x      = XW'(head_reg);
    assign cnt_x    = XW'(cmd.count);
    assign room_x   = XW'(rss_pkg::DEPTH) - n_x;
    assign most_x   = n_x - 1'b1;
    assign ins_clip = cnt_x > room_x;
    assign ins_c    = ins_clip ? room_x : cnt_x;
    assign era_clip = cnt_x > most_x;
    assign era_c    = era_clip ? most_x : cnt_x;
    assign era_wrap = (h_x + era_c) > most_x;
    assign era_w    = h_x + era_c - most_x;
    assign era_lo   = h_x + 1'b1 + era_c;

    // New head after a rotation: remainder folded for negative shifts
    assign mv_raw   = XW'(div_rsp.rem);
    assign mv_r     = (neg_reg && (mv_raw != '0)) ? (n_x - mv_raw) : mv_raw;
    assign mv_sum   = h_x + mv_r;
    assign mv_head  = (mv_sum >= n_x) ? (mv_sum - n_x) : mv_sum;

    // Slot zero reads as zero until first written after reset
    assign rd_data  = rd_zero_reg ? '0 : rd_q_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        dist_next      = dist_reg;
        left_next      = left_reg;
        up_next        = up_reg;
        ins_next       = ins_reg;
        st_next        = st_reg;
        neg_next       = neg_reg;
        value_next     = value_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        rd_en          = 1'b0;
        raddr          = ptr_reg;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = rd_data;
        div_req        = '0;
        emit           = '0;

        // Write back the entry read in the previous cycle
        if (pend_reg)
            we = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = cfg_data;
                    count_next = CW'(1);
                    head_next  = '0;
                end
                else if (cmd_valid)
                begin
                    value_next = cmd.value;
                    st_next    = 1'b0;
                    unique case (cmd.kind)
                        rss_pkg::KIND_INSERT:
                        begin
                            st_next  = ins_clip;
                            ins_next = 1'b1;
                            if (ins_c == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                count_next = CW'(n_x + ins_c);
                                left_next  = CW'(ins_c);
                                up_next    = 1'b1;
                                dist_next  = AW'(ins_c);
                                end_next   = AW'(h_x + 1'b1);
                                if ((h_x + 1'b1) > most_x)
                                begin
                                    ptr_next   = AW'(h_x + 1'b1);
                                    state_next = ST_FILL;
                                end
                                else
                                begin
                                    ptr_next   = AW'(most_x);
                                    state_next = ST_COPY;
                                end
                            end
                        end
                        rss_pkg::KIND_ERASE:
                        begin
                            st_next  = era_clip;
                            ins_next = 1'b0;
                            up_next  = 1'b0;
                            if (era_c == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else if (!era_wrap)
                            begin
                                // run after the head stays inside the block
                                count_next = CW'(n_x - era_c);
                                ptr_next   = AW'(era_lo);
                                end_next   = AW'(most_x);
                                dist_next  = AW'(era_c);
                                if (era_lo > most_x)
                                    state_next = ST_FINISH;
                                else
                                    state_next = ST_COPY;
                            end
                            else
                            begin
                                // run wraps: drop the tail, slide the front down
                                count_next = CW'(h_x + 1'b1 - era_w);
                                head_next  = AW'(h_x - era_w);
                                ptr_next   = AW'(era_w);
                                end_next   = head_reg;
                                dist_next  = AW'(era_w);
                                state_next = ST_COPY;
                            end
                        end
                        rss_pkg::KIND_MOVE:
                        begin
                            neg_next         = cmd.shift[rss_pkg::SHIFT_W-1];
                            div_req.start    = 1'b1;
                            div_req.dividend = cmd.shift[rss_pkg::SHIFT_W-1]
                                             ? (rss_pkg::SHIFT_W'(0) - cmd.shift)
                                             : cmd.shift;
                            div_req.divisor  = count_reg;
                            state_next       = ST_DIV;
                        end
                        rss_pkg::KIND_SHOW:
                        begin
                            ptr_next   = head_reg;
                            left_next  = count_reg;
                            state_next = ST_SHOW_RD;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // One entry moved per cycle: read here, written next cycle
            ST_COPY:
            begin
                rd_en          = 1'b1;
                raddr          = ptr_reg;
                pend_next      = 1'b1;
                pend_addr_next = up_reg ? (ptr_reg + dist_reg) : (ptr_reg - dist_reg);
                if (ptr_reg == end_reg)
                    state_next = ST_DRAIN;
                else if (up_reg)
                    ptr_next = ptr_reg - 1'b1;
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            ST_DRAIN:
            begin
                if (ins_reg)
                begin
                    ptr_next   = head_reg + 1'b1;
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            // Copies of the inserted value right after the head
            ST_FILL:
            begin
                we        = 1'b1;
                waddr     = ptr_reg;
                wdata     = value_reg;
                ptr_next  = ptr_reg + 1'b1;
                left_next = left_reg - 1'b1;
                if (left_reg == CW'(1))
                    state_next = ST_FINISH;
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    head_next  = AW'(mv_head);
                    state_next = ST_FINISH;
                end
            end

            ST_SHOW_RD:
            begin
                rd_en      = 1'b1;
                raddr      = ptr_reg;
                left_next  = left_reg - 1'b1;
                ptr_next   = ((XW'(ptr_reg) + 1'b1) == n_x) ? '0 : (ptr_reg + 1'b1);
                state_next = ST_SHOW_WAIT;
            end

            ST_SHOW_WAIT:
            begin
                emit.valid  = 1'b1;
                emit.value  = rd_data;
                emit.last   = (left_reg == '0);
                emit.status = 1'b0;
                if (out_free)
                    state_next = (left_reg == '0) ? ST_IDLE : ST_SHOW_RD;
            end

            ST_FINISH:
            begin
                emit.valid  = 1'b1;
                emit.value  = '0;
                emit.last   = 1'b1;
                emit.status = st_reg;
                if (out_free)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_ready  = (state_reg == ST_IDLE);
    assign cmd_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.count = count_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= CW'(1);
            head_reg       <= '0;
            pend_reg       <= 1'b0;
            zero_valid_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            pend_reg  <= pend_next;
            if (we && (waddr == '0))
                zero_valid_reg <= 1'b1;
            if (rd_en)
                rd_zero_reg <= (raddr == '0) && !zero_valid_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        dist_reg      <= dist_next;
        left_reg      <= left_next;
        up_reg        <= up_next;
        ins_reg       <= ins_next;
        st_reg        <= st_next;
        neg_reg       <= neg_next;
        pend_addr_reg <= pend_addr_next;
        value_reg     <= value_next;
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Memory read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_q_reg <= mem[raddr];
    end

endmodule

[rtl/ring_sequence_store.sv]
// Top level of the ring sequence store: stream ports, result register.
// Depends on rss_pkg and rss_engine.
//
//  channel   | direction | fields
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tuser: kind; tdata: value, count, shift
//  m_axis    | out       | tdata: item_value; tlast: last_item; tuser: status
//  cfg       | in        | cfg_data: init_value (restarts the sequence)
//
// Insert shifts the entries after the head, then writes count copies; erase
// slides the remaining entries down; move runs in the bit-serial remainder
// unit; show reads and emits one entry at a time (single registered read port).
// Reset clears the control state; slot zero reads as zero until written, no
// clearing pass. A finished result waits in the output register while the
// next transaction is accepted; the engine stalls only when that register
// is still full.
module ring_sequence_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rss_pkg::IN_DATA_W-1:0] s_axis_tdata,   // value[31:0], count[38:32], shift[70:39], zero pad
    input  logic [1:0]                    s_axis_tuser,   // kind[1:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // item_value[31:0]
    output logic                          m_axis_tlast,
    output logic [0:0]                    m_axis_tuser,   // status[0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data
);

    rss_pkg::rss_cmd_t  cmd;
    rss_pkg::rss_emit_t emit;
    rss_pkg::rss_stat_t stat;
    logic               out_free;
    logic               load;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_value_reg;
    logic               out_last_reg;
    logic               out_status_reg;

    // Unpack the incoming transaction
    assign cmd.kind  = rss_pkg::rss_kind_t'(s_axis_tuser);
    assign cmd.value = s_axis_tdata[31:0];
    assign cmd.count = s_axis_tdata[38:32];
    assign cmd.shift = s_axis_tdata[70:39];

    rss_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .emit      (emit),
        .stat      (stat)
    );

    // Output register
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load     = emit.valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= emit.value;
            out_last_reg   <= emit.last;
            out_status_reg <= emit.status;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_status_reg;

    // Length stays between one and capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.count != '0) && (stat.count <= rss_pkg::CW'(rss_pkg::DEPTH)))
        else $error("entry count out of range");

    // Configuration and commands never complete together
    a_cfg_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && s_axis_tvalid && s_axis_tready))
        else $error("config write and command accepted together");

    // A config write leaves a single entry
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (stat.count == rss_pkg::CW'(1)) && stat.idle)
        else $error("sequence not restarted by config write");

    // An accepted command occupies the engine
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !stat.idle)
        else $error("engine idle right after command");

endmodule

[tb/rss_sequence_checker.sv]
`timescale 1ns / 1ps
// Result checker for the ring sequence store: watches the command, result and
// init_value channels, keeps its own copy of the ring and compares every result.
// Depends on rss_pkg.
module rss_sequence_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value[31:0], count[38:32], shift[70:39], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // item_value[31:0]
    input  logic        m_axis_tlast,
    input  logic [0:0]  m_axis_tuser,   // status[0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic [31:0] item_value;
        logic        last_item;
        logic        status;
    } seq_result_t;

    // Predicted ring contents, in slot order, and the head slot
    logic [31:0]  init_reg;
    logic [31:0]  ring_mem [rss_pkg::DEPTH];
    int unsigned  ring_len;
    int unsigned  head_slot;
    seq_result_t  expected_q[$];
    int           err_cnt  = 0;
    int           seen_cnt = 0;

    // Sequence collapses to one entry holding init_value
    task automatic restart_ring();
        for (int i = 0; i < rss_pkg::DEPTH; i++)
            ring_mem[i] = '0;
        ring_mem[0] = init_reg;
        ring_len    = 1;
        head_slot   = 0;
    endtask

    // Update the ring for one command and queue the results it produces
    task automatic apply_command(input rss_pkg::rss_kind_t kind, input logic [31:0] val,
                                 input logic [6:0] cnt, input logic [31:0] sraw);
        logic [31:0] line [rss_pkg::DEPTH];
        int unsigned amount;
        int unsigned rot;
        logic [31:0] mag;
        logic        clipped;
        seq_result_t res;
        clipped = 1'b0;
        amount  = cnt;
        // ring unrolled from the head
        for (int i = 0; i < ring_len; i++)
            line[i] = ring_mem[(head_slot + i) % ring_len];
        if (kind == rss_pkg::KIND_SHOW)
        begin
            for (int i = 0; i < ring_len; i++)
            begin
                res.item_value = line[i];
                res.last_item  = (i == ring_len - 1);
                res.status     = 1'b0;
                expected_q.push_back(res);
            end
        end
        else
        begin
            case (kind)
                rss_pkg::KIND_INSERT:
                begin
                    // clip to the free room
                    if (amount > rss_pkg::DEPTH - ring_len)
                    begin
                        amount  = rss_pkg::DEPTH - ring_len;
                        clipped = 1'b1;
                    end
                    if (amount > 0)
                    begin
                        ring_mem[0] = line[0];
                        for (int i = 0; i < amount; i++)
                            ring_mem[1 + i] = val;
                        for (int i = 1; i < ring_len; i++)
                            ring_mem[amount + i] = line[i];
                        ring_len  = ring_len + amount;
                        head_slot = 0;
                    end
                end
                rss_pkg::KIND_ERASE:
                begin
                    // the head entry always survives
                    if (amount > ring_len - 1)
                    begin
                        amount  = ring_len - 1;
                        clipped = 1'b1;
                    end
                    if (amount > 0)
                    begin
                        ring_mem[0] = line[0];
                        for (int i = 1; i < ring_len - amount; i++)
                            ring_mem[i] = line[i + amount];
                        ring_len  = ring_len - amount;
                        head_slot = 0;
                    end
                end
                default:
                begin
                    // rotate by |shift| mod length, backward when negative
                    mag = sraw[31] ? (32'd0 - sraw) : sraw;
                    rot = mag % ring_len;
                    if (sraw[31])
                        rot = (ring_len - rot) % ring_len;
                    head_slot = (head_slot + rot) % ring_len;
                end
            endcase
            res.item_value = '0;
            res.last_item  = 1'b1;
            res.status     = clipped;
            expected_q.push_back(res);
        end
    endtask

    // Sample all three channels at each edge: results first, then config, then commands
    always @(posedge clk or negedge rst_n)
    begin
        seq_result_t got;
        seq_result_t want;
        if (!rst_n)
        begin
            init_reg = '0;
            restart_ring();
            expected_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.item_value = m_axis_tdata;
                got.last_item  = m_axis_tlast;
                got.status     = m_axis_tuser[0];
                seen_cnt++;
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result value %h last %b status %b",
                                 $time, got.item_value, got.last_item, got.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: result mismatch: expected value %h last %b ",
                                      "status %b, got value %h last %b status %b"},
                                     $time, want.item_value, want.last_item, want.status,
                                     got.item_value, got.last_item, got.status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                init_reg = cfg_data;
                restart_ring();
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(rss_pkg::rss_kind_t'(s_axis_tuser), s_axis_tdata[31:0],
                              s_axis_tdata[38:32], s_axis_tdata[70:39]);
        end
        mismatches   <= err_cnt;
        pending      <= expected_q.size();
        results_seen <= seen_cnt;
    end

endmodule

[tb/ring_sequence_store_test.sv]
`timescale 1ns / 1ps
// Testbench top for the ring sequence store: clock, reset, command and
// init_value stimulus, random result back-pressure and the final verdict.
// Depends on rss_pkg, ring_sequence_store and rss_sequence_checker.
module ring_sequence_store_test;

    localparam int STALL_LIMIT = 4000;  // cycles with no transaction at all
    localparam int TAIL_CYCLES = 200;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 50;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int   mismatches;
    int   pending;
    int   results_seen;
    logic quiet;            // no idling on either side while set
    int   idle_cycles = 0;
    int   kind_seen [4];
    int   init_writes = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ring_sequence_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    rss_sequence_checker seq_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    // One command transaction; tvalid stays high into the next command when no gap
    task automatic send_cmd(input rss_pkg::rss_kind_t kind, input logic [31:0] val,
                            input logic [6:0] cnt, input logic [31:0] shift);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, shift, cnt, val};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
        kind_seen[kind]++;
    endtask

    // Drop tvalid and wait for every predicted result to arrive
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_init(input logic [31:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        init_writes++;
    endtask

    // Random command, weighted to grow and shrink the ring through its full range
    task automatic random_cmd();
        int          pick;
        logic [31:0] val;
        logic [6:0]  cnt;
        logic [31:0] shift;
        pick  = $urandom_range(0, 99);
        val   = $urandom();
        shift = $urandom();
        cnt   = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 64))
                                            : 7'($urandom_range(0, 6));
        case ($urandom_range(0, 7))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
            shift = $urandom_range(0, 40) - 20;
        if (pick < 35)
            send_cmd(rss_pkg::KIND_INSERT, val, cnt, shift);
        else if (pick < 60)
            send_cmd(rss_pkg::KIND_ERASE, val, cnt, shift);
        else if (pick < 80)
            send_cmd(rss_pkg::KIND_MOVE, val, cnt, shift);
        else
            send_cmd(rss_pkg::KIND_SHOW, val, cnt, shift);
    endtask

    // Result side: random stall before each result transaction
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        logic [31:0] phase_init;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rss_pkg::KIND_INSERT;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        quiet         <= 1'b0;
        for (int i = 0; i < 4; i++)
            kind_seen[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset sequence, extremes, clipping and clamping
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_INSERT, 32'h7FFF_FFFF, 7'd0,  32'h0);          // zero count
        send_cmd(rss_pkg::KIND_INSERT, 32'h8000_0000, 7'd3,  32'hFFFF_FFFF);
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_MOVE,   32'h0,         7'd0,  32'h1);
        send_cmd(rss_pkg::KIND_MOVE,   32'h0,         7'd0,  32'hFFFF_FFFF);
        send_cmd(rss_pkg::KIND_MOVE,   32'h0,         7'd0,  32'h8000_0000);  // most negative shift
        send_cmd(rss_pkg::KIND_MOVE,   32'h0,         7'd0,  32'h7FFF_FFFF);
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_ERASE,  32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_ERASE,  32'h0,         7'd2,  32'h0);
        send_cmd(rss_pkg::KIND_INSERT, $urandom(),    7'd64, 32'h0);          // clipped at capacity
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_INSERT, 32'h1234_5678, 7'd1,  32'h0);          // full ring
        send_cmd(rss_pkg::KIND_MOVE,   32'h0,         7'd0,  $urandom());
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_ERASE,  32'h0,         7'd64, 32'h0);          // clamped to keep head
        send_cmd(rss_pkg::KIND_ERASE,  32'h0,         7'd1,  32'h0);          // single entry
        send_cmd(rss_pkg::KIND_INSERT, 32'hFFFF_FFFF, 7'd63, 32'h0);          // exactly fills
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        send_cmd(rss_pkg::KIND_ERASE,  32'h0,         7'd63, 32'h0);
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        write_init(32'h8000_0000);
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);
        write_init(32'h7FFF_FFFF);
        send_cmd(rss_pkg::KIND_SHOW,   32'h0,         7'd0,  32'h0);

        // Random phases, each starting from a fresh init_value
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_init = 32'h0;
                1: phase_init = 32'hFFFF_FFFF;
                2: phase_init = 32'h8000_0000;
                default: phase_init = $urandom();
            endcase
            write_init(phase_init);
            quiet <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    quiet <= !quiet;
                random_cmd();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d insert, %0d erase, %0d move, %0d show",
                 kind_seen[rss_pkg::KIND_INSERT] + kind_seen[rss_pkg::KIND_ERASE] +
                 kind_seen[rss_pkg::KIND_MOVE] + kind_seen[rss_pkg::KIND_SHOW],
                 kind_seen[rss_pkg::KIND_INSERT], kind_seen[rss_pkg::KIND_ERASE],
                 kind_seen[rss_pkg::KIND_MOVE], kind_seen[rss_pkg::KIND_SHOW]);
        $display("%0d init_value writes, %0d results compared, %0d missing",
                 init_writes, results_seen, pending);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
